/* rtl/core/age_replacement_tag_store_unit_assert.svh */
// ---------------------------------------------------------------------------
// age replacement tag store assertion macros
// concurrent property helpers shared by the tag store rtl
// ---------------------------------------------------------------------------
`ifndef AGE_REPLACEMENT_TAG_STORE_UNIT_ASSERT_SVH
`define AGE_REPLACEMENT_TAG_STORE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ARTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tag store assertion failed");

// next-cycle implication, disabled during reset
`define ARTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tag store assertion failed");

`endif

/* rtl/core/arts_pkg.sv */
// ---------------------------------------------------------------------------
// arts_pkg
// shared sizes, types and codes of the age replacement tag store
// ---------------------------------------------------------------------------
package arts_pkg;

  localparam int unsigned ENTRIES    = 32;
  localparam int unsigned AGE_BITS   = 16;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned IN_DATA_W  = 2 * KEY_W;
  localparam int unsigned OUT_DATA_W = 8;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  localparam age_t AGE_MAX = '1;

  // one directory entry as held in the ram, x key in the lowest bits
  typedef struct packed {
    age_t age;
    key_t y;
    key_t x;
  } entry_t;

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // low bits of an entry index, zero extended for small directories
  function automatic slot_t to_slot(idx_t idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = (IDX_W + SLOT_W)'(idx);
    return ext[SLOT_W-1:0];
  endfunction

endpackage

/* rtl/core/age_replacement_tag_store_unit.sv */
// ---------------------------------------------------------------------------
// age_replacement_tag_store_unit
// tag directory of a chunk cache with age based replacement and lookup/free
// ---------------------------------------------------------------------------
// a new request is taken only once the previous one has walked all entries
//   through the single read port of the entry ram and its result is registered
// reset: every entry empty at once (valid bits in flops), no clearing pass;
//   tag and age ram contents are only used for valid entries
// ---------------------------------------------------------------------------
`include "age_replacement_tag_store_unit_assert.svh"

module age_replacement_tag_store_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request side
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [arts_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,  // key_x, key_y
  input  logic [0:0]                         s_axis_tuser_i,  // opcode
  // result side
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [arts_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o   // slot, found, evicted_valid
);

  // control state
  arts_pkg::state_e state_q, state_d;
  arts_pkg::cnt_t   cnt_q, cnt_d;
  logic [arts_pkg::ENTRIES-1:0] valid_q, valid_d;

  // latched request
  arts_pkg::op_e  op_q, op_d;
  arts_pkg::key_t kx_q, kx_d, ky_q, ky_d;

  // read pipeline: entry coming back from the ram this cycle
  logic           proc_vld_q, proc_vld_d;
  arts_pkg::idx_t proc_idx_q, proc_idx_d;

  // scan trackers
  logic           best_vld_q, best_vld_d;
  arts_pkg::idx_t best_idx_q, best_idx_d;
  arts_pkg::age_t best_age_q, best_age_d;
  logic           empty_vld_q, empty_vld_d;
  arts_pkg::idx_t empty_idx_q, empty_idx_d;
  logic           hit_q, hit_d;
  arts_pkg::idx_t hit_idx_q, hit_idx_d;

  // result register
  logic                            m_valid_q, m_valid_d;
  logic [arts_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

  // ram ports
  logic             rd_en;
  arts_pkg::idx_t   rd_addr;
  arts_pkg::entry_t rd_data;
  logic             wr_en;
  arts_pkg::idx_t   wr_addr;
  arts_pkg::entry_t wr_data;

  logic             in_fire;
  logic             out_free;
  logic             done_fire;
  logic             proc_entry_valid;
  logic             key_match;
  arts_pkg::age_t   aged;
  arts_pkg::idx_t   victim_idx;
  arts_pkg::idx_t   slot_idx;

  // a request is taken only between scans, even while a result waits
  assign s_axis_tready_o = (state_q == arts_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign done_fire       = (state_q == arts_pkg::ST_DONE) && out_free;

  // reads start with entry 0 in the accept cycle, then one entry per cycle
  assign rd_en   = in_fire ||
                   ((state_q == arts_pkg::ST_SCAN) && (cnt_q < arts_pkg::CNT_W'(arts_pkg::ENTRIES)));
  assign rd_addr = (state_q == arts_pkg::ST_IDLE) ? '0 : cnt_q[arts_pkg::IDX_W-1:0];

  // entry under inspection, valid bits are stable during a scan
  assign proc_entry_valid = valid_q[proc_idx_q];
  assign key_match        = proc_entry_valid && (rd_data.x == kx_q) && (rd_data.y == ky_q);
  assign aged             = (rd_data.age == arts_pkg::AGE_MAX) ? rd_data.age
                                                               : rd_data.age + 1'b1;

  // first empty entry wins, else the first oldest one
  assign victim_idx = empty_vld_q ? empty_idx_q : best_idx_q;
  assign slot_idx   = (op_q == arts_pkg::OP_STORE) ? victim_idx
                                                   : (hit_q ? hit_idx_q : '0);

  // write port: aging write-back during a store scan, victim fill at the end
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx_q;
    wr_data = '{age: aged, y: rd_data.y, x: rd_data.x};
    if (done_fire && (op_q == arts_pkg::OP_STORE)) begin
      wr_en   = 1'b1;
      wr_addr = victim_idx;
      wr_data = '{age: '0, y: ky_q, x: kx_q};
    end else if (proc_vld_q && (op_q == arts_pkg::OP_STORE) && proc_entry_valid) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    op_d        = op_q;
    kx_d        = kx_q;
    ky_d        = ky_q;
    proc_vld_d  = rd_en;
    proc_idx_d  = rd_addr;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_age_d  = best_age_q;
    empty_vld_d = empty_vld_q;
    empty_idx_d = empty_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_data_d    = m_data_q;

    // trackers follow the entry coming back from the ram
    if (proc_vld_q) begin
      if (!proc_entry_valid && !empty_vld_q) begin
        empty_vld_d = 1'b1;
        empty_idx_d = proc_idx_q;
      end
      // strict compare keeps the lowest index among equal ages
      if (proc_entry_valid && (!best_vld_q || (rd_data.age > best_age_q))) begin
        best_vld_d = 1'b1;
        best_idx_d = proc_idx_q;
        best_age_d = rd_data.age;
      end
      if (key_match && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = proc_idx_q;
      end
    end

    case (state_q)
      arts_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_d        = arts_pkg::op_e'(s_axis_tuser_i[0]);
          kx_d        = s_axis_tdata_i[arts_pkg::KEY_W-1:0];
          ky_d        = s_axis_tdata_i[2*arts_pkg::KEY_W-1:arts_pkg::KEY_W];
          cnt_d       = arts_pkg::CNT_W'(1);
          best_vld_d  = 1'b0;
          empty_vld_d = 1'b0;
          hit_d       = 1'b0;
          state_d     = arts_pkg::ST_SCAN;
        end
      end
      arts_pkg::ST_SCAN: begin
        if (rd_en) begin
          cnt_d = cnt_q + arts_pkg::CNT_W'(1);
        end
        // last entry is inspected in this cycle
        if (cnt_q == arts_pkg::CNT_W'(arts_pkg::ENTRIES)) begin
          state_d = arts_pkg::ST_DONE;
        end
      end
      arts_pkg::ST_DONE: begin
        if (done_fire) begin
          if (op_q == arts_pkg::OP_STORE) begin
            valid_d[victim_idx] = 1'b1;
          end else if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
          end
          m_valid_d = 1'b1;
          m_data_d  = {1'b0,
                       (op_q == arts_pkg::OP_STORE) && !empty_vld_q,
                       (op_q == arts_pkg::OP_LOOKUP) && hit_q,
                       arts_pkg::to_slot(slot_idx)};
          state_d   = arts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = arts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arts_pkg::ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      proc_vld_q  <= 1'b0;
      best_vld_q  <= 1'b0;
      empty_vld_q <= 1'b0;
      hit_q       <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      proc_vld_q  <= proc_vld_d;
      best_vld_q  <= best_vld_d;
      empty_vld_q <= empty_vld_d;
      hit_q       <= hit_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    kx_q        <= kx_d;
    ky_q        <= ky_d;
    proc_idx_q  <= proc_idx_d;
    best_idx_q  <= best_idx_d;
    best_age_q  <= best_age_d;
    empty_idx_q <= empty_idx_d;
    hit_idx_q   <= hit_idx_d;
    m_data_q    <= m_data_d;
  end

  // entry ram: {age, y key, x key} per entry
  arts_ram #(
    .WIDTH ($bits(arts_pkg::entry_t)),
    .DEPTH (arts_pkg::ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // store fill leaves the victim valid
  `ARTS_ASSERT_NEXT(a_store_sets_valid, clk_i, rst_ni,
    done_fire && (op_q == arts_pkg::OP_STORE), valid_q[$past(victim_idx)])
  // lookup hit frees the entry it found
  `ARTS_ASSERT_NEXT(a_hit_frees_entry, clk_i, rst_ni,
    done_fire && (op_q == arts_pkg::OP_LOOKUP) && hit_q, !valid_q[$past(hit_idx_q)])
  // no ram write outside a running request
  `ARTS_ASSERT_IMPL(a_no_idle_write, clk_i, rst_ni,
    state_q == arts_pkg::ST_IDLE, !wr_en)
  // a store result never reports a found key
  `ARTS_ASSERT_NEXT(a_store_not_found, clk_i, rst_ni,
    done_fire && (op_q == arts_pkg::OP_STORE), !m_axis_tdata_o[arts_pkg::SLOT_W])

endmodule

/* rtl/core/arts_ram.sv */
// ---------------------------------------------------------------------------
// arts_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module arts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
